// ===== design/tii_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tabulated interval integrator package
// Widths, codes, state encoding and control bundles shared by the
// integrator's modules.
// ----------------------------------------------------------------------------
package tii_pkg;

  // Field and datapath widths.
  localparam int MassW    = 32;
  localparam int DensW    = 64;
  localparam int WordW    = MassW + DensW;
  localparam int AccW     = 128;
  localparam int MacAW    = 96;
  localparam int MacBW    = 64;
  localparam int LimbW    = 32;
  localparam int CntW     = 11;
  localparam int WidthW   = 31;
  localparam int StatW    = 2;
  localparam int IdxW     = 10;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;
  localparam int ArithW   = 36;
  localparam int ResShift = 25;

  // Register reset values.
  localparam logic [CntW-1:0]   EntriesRst = 11'd2;
  localparam logic [WidthW-1:0] WidthRst   = 31'd1677722;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_TABLE_ENTRIES  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_INTERVAL_WIDTH = 1'b1;

  // Range status codes.
  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_BELOW  = 2'd1,
    ST_BEYOND = 2'd2
  } range_status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_SWEEP,
    S_PLAN,
    S_MAC_GO,
    S_MAC_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  // Multiply-accumulate control.
  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

endpackage

// ===== design/tii_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table memory
// One write port and one read port with registered read data. Each word
// holds a log-mass point above its density.
// ----------------------------------------------------------------------------
module tii_mem #(
  parameter int Depth = 1024,
  parameter int Aw    = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [Aw-1:0]            waddr,
  input  logic [tii_pkg::WordW-1:0] wdata,
  input  logic [Aw-1:0]            raddr,
  output logic [tii_pkg::WordW-1:0] rdata
);
  import tii_pkg::*;

  logic [WordW-1:0] mem_r [Depth];
  logic [WordW-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tii_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Adds a 96 by 64 bit product into a 128-bit accumulator, one 32 by 32 bit
// partial product per cycle, with a register between multiply and add.
// ----------------------------------------------------------------------------
module tii_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tii_pkg::mac_ctl_t         ctl,
  input  logic [tii_pkg::MacAW-1:0] a,
  input  logic [tii_pkg::MacBW-1:0] b,
  output logic                      busy,
  output logic [tii_pkg::AccW-1:0]  acc
);
  import tii_pkg::*;

  localparam int NumA = MacAW / LimbW;
  localparam int NumB = MacBW / LimbW;
  localparam logic [2:0] LastStep = 3'(NumA * NumB);

  logic [MacAW-1:0]   a_r;
  logic [MacBW-1:0]   b_r;
  logic [2:0]         step_r;
  logic               run_r;
  logic               pv_r;
  logic [2*LimbW-1:0] pp_r;
  logic [1:0]         sh_r;
  logic [AccW-1:0]    acc_r;
  logic [1:0]         ia;
  logic               ib;
  logic [LimbW-1:0]   la;
  logic [LimbW-1:0]   lb;

  // Limb selection for the current step.
  always_comb begin
    ia = step_r[2:1];
    ib = step_r[0];
    case (ia)
      2'd0:    la = a_r[LimbW-1:0];
      2'd1:    la = a_r[2*LimbW-1:LimbW];
      2'd2:    la = a_r[3*LimbW-1:2*LimbW];
      default: la = '0;
    endcase
    lb = ib ? b_r[2*LimbW-1:LimbW] : b_r[LimbW-1:0];
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      step_r <= '0;
    end else if (ctl.start) begin
      run_r  <= 1'b1;
      pv_r   <= 1'b0;
      step_r <= '0;
    end else if (run_r) begin
      if (step_r < LastStep) begin
        step_r <= step_r + 3'd1;
        pv_r   <= 1'b1;
      end else begin
        run_r <= 1'b0;
        pv_r  <= 1'b0;
      end
    end else begin
      pv_r <= 1'b0;
    end
  end

  // Operands, partial product and accumulator.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r <= a;
      b_r <= b;
    end
    if (run_r && step_r < LastStep) begin
      pp_r <= la * lb;
      sh_r <= ia + 2'(ib);
    end
    if (ctl.start && ctl.clear) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + (AccW'(pp_r) << {sh_r, 5'b0});
    end
  end

  assign busy = run_r | pv_r;
  assign acc  = acc_r;

endmodule

// ===== design/tii_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Floors a 128-bit dividend by a 32-bit divisor, one quotient bit per cycle,
// keeping the low 64 quotient bits.
// ----------------------------------------------------------------------------
module tii_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tii_pkg::AccW-1:0]  num,
  input  logic [tii_pkg::LimbW-1:0] den,
  output logic                      busy,
  output logic [tii_pkg::DensW-1:0] quo
);
  import tii_pkg::*;

  logic [AccW-1:0]  num_r;
  logic [LimbW-1:0] den_r;
  logic [LimbW-1:0] rem_r;
  logic [DensW-1:0] quo_r;
  logic [6:0]       cnt_r;
  logic             run_r;
  logic [LimbW:0]   trial;
  logic [LimbW:0]   diff;
  logic             fits;

  // One restoring step.
  always_comb begin
    trial = {rem_r, num_r[AccW-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      if (cnt_r == 7'd127) begin
        run_r <= 1'b0;
      end
      cnt_r <= cnt_r + 7'd1;
    end
  end

  // Shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= num_r << 1;
      rem_r <= fits ? diff[LimbW-1:0] : trial[LimbW-1:0];
      quo_r <= {quo_r[DensW-2:0], fits};
    end
  end

  assign busy = run_r;
  assign quo  = quo_r;

endmodule

// ===== design/tabulated_interval_integrator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tabulated interval integrator
// Trapezoid integration of a tabulated density over a log-mass interval,
// with the table held in a single-port-read memory.
// ----------------------------------------------------------------------------
// A load beat is written straight into the table. A query runs a scan of
// the memory, one read per cycle, then up to seven multiply-accumulate
// passes and two divisions for the end points. One item is worked at a
// time; a finished result waits in the output register while the next
// beat is taken. Reset clears control state only.
module tabulated_interval_integrator_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [tii_pkg::IdxW-1:0]     in_entry_index,
  input  logic signed [tii_pkg::MassW-1:0] in_entry_log_mass,
  input  logic [tii_pkg::DensW-1:0]    in_entry_density,
  input  logic signed [tii_pkg::MassW-1:0] in_query_log_mass,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tii_pkg::DensW-1:0]    out_number_density,
  output logic [tii_pkg::StatW-1:0]    out_range_status,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tii_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tii_pkg::CfgDataW-1:0] cfg_data
);
  import tii_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_LQ_A,
    OP_LQ_B,
    OP_HI_A,
    OP_HI_B,
    OP_END_L,
    OP_END_H,
    OP_CELLS
  } mac_op_t;

  function automatic logic signed [ArithW-1:0] clamp_off(
    input logic signed [ArithW-1:0] t,
    input logic signed [ArithW-1:0] s
  );
    return (t < 0) ? '0 : ((t > s) ? s : t);
  endfunction

  state_t state_r, state_nxt;
  mac_op_t op_r;
  logic [CntW-1:0]   entries_r;
  logic [WidthW-1:0] width_r;
  logic signed [ArithW-1:0] q_r, hi_r;
  logic [CW-1:0]  n_r, n_clamped, sk_r;
  logic           rv_r;
  logic [AW-1:0]  rk_r, lpos_r, hpos_r, l_r, h_r;
  logic           fl_r, fh_r, same_r;
  logic signed [MassW-1:0] m0_r, m1_r, ml_r, ml1_r, mh_r, m_rd;
  logic [DensW-1:0] dl_r, dl1_r, dh_r, dh1_r, dq_r, dhi_r, d_rd;
  logic [2:0]     fstep_r;
  logic [AW:0]    sw_r;
  logic           swv_r;
  logic [MacAW-1:0] p_r;
  range_status_t  status_r, scan_status;
  logic           out_valid_r;
  logic [DensW-1:0] out_dens_r;
  logic [StatW-1:0] out_stat_r;

  logic signed [ArithW-1:0] s_v, tq_v, th_v, len_l, len_h;
  logic           s_pos;
  logic           mem_we;
  logic [AW-1:0]  raddr;
  logic [WordW-1:0] rdata;
  mac_ctl_t       mac_ctl;
  logic [MacAW-1:0] mac_a;
  logic [MacBW-1:0] mac_b;
  logic           mac_busy, div_busy, div_start;
  logic [AccW-1:0] acc;
  logic [DensW-1:0] quo;
  logic [DensW-1:0] sat_res;
  logic           in_acc, query_acc;

  // Table memory, mass point above density.
  tii_mem #(.Depth(TABLE_DEPTH), .Aw(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_entry_index)),
    .wdata ({in_entry_log_mass, in_entry_density}),
    .raddr (raddr),
    .rdata (rdata)
  );

  tii_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .busy  (mac_busy),
    .acc   (acc)
  );

  tii_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc),
    .den   (s_v[LimbW-1:0]),
    .busy  (div_busy),
    .quo   (quo)
  );

  // Handshake decode and read data split.
  assign in_acc    = in_valid && !in_stall;
  assign query_acc = in_acc && (in_kind == KIND_QUERY);
  assign m_rd      = rdata[WordW-1:DensW];
  assign d_rd      = rdata[DensW-1:0];

  // Entry count clamped to the table.
  always_comb begin
    if (entries_r < 11'd2) begin
      n_clamped = CW'(2);
    end else if (int'(entries_r) > TABLE_DEPTH) begin
      n_clamped = CW'(TABLE_DEPTH);
    end else begin
      n_clamped = CW'(entries_r);
    end
  end

  // Spacing, end offsets and piece lengths.
  always_comb begin
    s_v   = ArithW'(m1_r) - ArithW'(m0_r);
    s_pos = s_v > 0;
    tq_v  = clamp_off(q_r - ArithW'(ml_r), s_v);
    th_v  = clamp_off(hi_r - ArithW'(mh_r), s_v);
    len_l = ArithW'(ml1_r) - q_r;
    len_h = hi_r - ArithW'(mh_r);
  end

  // Outcome of the scan.
  always_comb begin
    if (fl_r && lpos_r == '0) begin
      scan_status = ST_BELOW;
    end else if (!fl_r || !fh_r) begin
      scan_status = ST_BEYOND;
    end else begin
      scan_status = ST_OK;
    end
  end

  // Operands for each multiply-accumulate pass.
  always_comb begin
    mac_a = '0;
    mac_b = '0;
    if (same_r) begin
      mac_a = MacAW'(dl_r) + MacAW'(dl1_r);
      mac_b = MacBW'(width_r);
    end else begin
      case (op_r)
        OP_LQ_A: begin
          mac_a = MacAW'(dl_r);
          mac_b = MacBW'($unsigned(s_v - tq_v));
        end
        OP_LQ_B: begin
          mac_a = MacAW'(dl1_r);
          mac_b = MacBW'($unsigned(tq_v));
        end
        OP_HI_A: begin
          mac_a = MacAW'(dh_r);
          mac_b = MacBW'($unsigned(s_v - th_v));
        end
        OP_HI_B: begin
          mac_a = MacAW'(dh1_r);
          mac_b = MacBW'($unsigned(th_v));
        end
        OP_END_L: begin
          mac_a = MacAW'(dq_r) + MacAW'(dl1_r);
          mac_b = MacBW'($unsigned(len_l));
        end
        OP_END_H: begin
          mac_a = MacAW'(dh_r) + MacAW'(dhi_r);
          mac_b = MacBW'($unsigned(len_h));
        end
        OP_CELLS: begin
          mac_a = p_r;
          mac_b = s_pos ? MacBW'(s_v[LimbW-1:0]) : '0;
        end
        default: begin
          mac_a = '0;
          mac_b = '0;
        end
      endcase
    end
  end

  // Scale to Q16.48 with saturation.
  assign sat_res = (acc[AccW-1:DensW+ResShift] != '0) ? '1 : acc[DensW+ResShift-1:ResShift];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (query_acc) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sk_r >= n_r && !rv_r) begin
          state_nxt = (scan_status == ST_OK) ? S_FETCH : S_OUT;
        end
      end
      S_FETCH: begin
        if (fstep_r == 3'd4) state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (sw_r >= {1'b0, h_r} && !swv_r) state_nxt = S_PLAN;
      end
      S_PLAN:   state_nxt = S_MAC_GO;
      S_MAC_GO: state_nxt = S_MAC_WAIT;
      S_MAC_WAIT: begin
        if (!mac_busy) begin
          if (same_r || op_r == OP_CELLS) begin
            state_nxt = S_OUT;
          end else if (op_r == OP_LQ_B || op_r == OP_HI_B) begin
            state_nxt = S_DIV_GO;
          end else begin
            state_nxt = S_MAC_GO;
          end
        end
      end
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (!div_busy) state_nxt = S_MAC_GO;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall      = (state_r != S_IDLE);
    mem_we        = in_acc && (in_kind == KIND_LOAD) && (int'(in_entry_index) < TABLE_DEPTH);
    mac_ctl.start = (state_r == S_MAC_GO);
    mac_ctl.clear = same_r || op_r == OP_LQ_A || op_r == OP_HI_A || op_r == OP_END_L;
    div_start     = (state_r == S_DIV_GO);
    case (state_r)
      S_SCAN:  raddr = sk_r[AW-1:0];
      S_SWEEP: raddr = sw_r[AW-1:0];
      S_FETCH: begin
        case (fstep_r)
          3'd0:    raddr = l_r;
          3'd1:    raddr = l_r + AW'(1);
          3'd2:    raddr = h_r;
          3'd3:    raddr = h_r + AW'(1);
          default: raddr = '0;
        endcase
      end
      default: raddr = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
      swv_r       <= 1'b0;
      fstep_r     <= '0;
      entries_r   <= EntriesRst;
      width_r     <= WidthRst;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && state_nxt == S_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      rv_r    <= (state_r == S_SCAN) && (sk_r < n_r);
      swv_r   <= (state_r == S_SWEEP) && (sw_r < {1'b0, h_r});
      fstep_r <= (state_r == S_FETCH) ? fstep_r + 3'd1 : 3'd0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TABLE_ENTRIES:  entries_r <= cfg_data[CntW-1:0];
          CFG_INTERVAL_WIDTH: width_r   <= cfg_data[WidthW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        q_r  <= ArithW'(in_query_log_mass);
        hi_r <= ArithW'(in_query_log_mass) + ArithW'(signed'({1'b0, width_r}));
        n_r  <= n_clamped;
        sk_r <= '0;
        fl_r <= 1'b0;
        fh_r <= 1'b0;
      end
      S_SCAN: begin
        if (sk_r < n_r) begin
          sk_r <= sk_r + CW'(1);
          rk_r <= sk_r[AW-1:0];
        end
        if (rv_r) begin
          if (rk_r == AW'(0)) m0_r <= m_rd;
          if (rk_r == AW'(1)) m1_r <= m_rd;
          if (!fl_r && ArithW'(m_rd) > q_r) begin
            fl_r   <= 1'b1;
            lpos_r <= rk_r;
          end
          if (!fh_r && ArithW'(m_rd) > hi_r) begin
            fh_r   <= 1'b1;
            hpos_r <= rk_r;
          end
        end
        if (state_nxt != S_SCAN) begin
          status_r <= scan_status;
          l_r      <= lpos_r - AW'(1);
          h_r      <= hpos_r - AW'(1);
        end
      end
      S_FETCH: begin
        case (fstep_r)
          3'd1: begin
            ml_r <= m_rd;
            dl_r <= d_rd;
          end
          3'd2: begin
            ml1_r <= m_rd;
            dl1_r <= d_rd;
          end
          3'd3: begin
            mh_r <= m_rd;
            dh_r <= d_rd;
          end
          3'd4: begin
            dh1_r  <= d_rd;
            same_r <= (l_r == h_r);
            sw_r   <= {1'b0, l_r} + (AW+1)'(2);
            p_r    <= ({1'b0, h_r} > {1'b0, l_r} + (AW+1)'(1)) ?
                      MacAW'(dl1_r) + MacAW'(dh_r) : '0;
          end
          default: ;
        endcase
      end
      S_SWEEP: begin
        if (sw_r < {1'b0, h_r}) sw_r <= sw_r + (AW+1)'(1);
        if (swv_r) p_r <= p_r + (MacAW'(d_rd) << 1);
      end
      S_PLAN: begin
        if (s_pos) begin
          op_r <= OP_LQ_A;
        end else begin
          op_r  <= OP_END_L;
          dq_r  <= dl_r;
          dhi_r <= dh_r;
        end
      end
      S_MAC_WAIT: begin
        if (state_nxt == S_MAC_GO) op_r <= mac_op_t'(op_r + 3'd1);
      end
      S_DIV_WAIT: begin
        if (!div_busy) begin
          if (op_r == OP_LQ_B) dq_r <= quo;
          else dhi_r <= quo;
          op_r <= mac_op_t'(op_r + 3'd1);
        end
      end
      S_OUT: begin
        if (state_nxt == S_IDLE) begin
          out_dens_r <= (status_r == ST_OK) ? sat_res : '0;
          out_stat_r <= status_r;
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_number_density = out_dens_r;
  assign out_range_status   = out_stat_r;

  // A query beat always starts the scan.
  a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> (state_r == S_SCAN))
    else $error("query beat did not start the scan");

  // A flagged result carries no density.
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_status != ST_OK) |-> (out_number_density == '0))
    else $error("out-of-range result with non-zero density");

  // The multiplier and divider never run together.
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mac_busy && div_busy))
    else $error("multiplier and divider busy together");

  // No table write while a query is in flight.
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !mem_we)
    else $error("table write during a query");

endmodule
